// File: hdl/ttpl_pkg.sv
// Package for the triangle table point locator.
// Holds table sizes, coordinate and product widths, codes, and the channel and control types.
// Used by every module of the block; depends on nothing.
package ttpl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int COORD_W     = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int SUM_W       = CROSS_W + 1;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_QUERY    = 2'd2,
        OP_RESERVED = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
    } tri_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] corner_a_x;
        logic signed [COORD_W-1:0] corner_a_y;
        logic signed [COORD_W-1:0] corner_b_x;
        logic signed [COORD_W-1:0] corner_b_y;
        logic signed [COORD_W-1:0] corner_c_x;
        logic signed [COORD_W-1:0] corner_c_y;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [COORD_W-1:0] hit_a_x;
        logic signed [COORD_W-1:0] hit_a_y;
        logic signed [COORD_W-1:0] hit_b_x;
        logic signed [COORD_W-1:0] hit_b_y;
        logic signed [COORD_W-1:0] hit_c_x;
        logic signed [COORD_W-1:0] hit_c_y;
        logic [CNT_W-1:0]          entry_count;
    } res_t;

    typedef struct packed {
        logic    load_req;
        logic    scan_start;
        logic    scan_run;
        logic    capture;
        logic    ins_write;
        logic    count_inc;
        logic    shift_rd;
        logic    shift_wr;
        logic    count_dec;
        logic    res_load;
        logic    res_hit;
        status_t res_status;
    } ctl_t;

    typedef struct packed {
        logic full;
        logic left_zero;
        logic pipe_empty;
        logic hit;
        logic shift_more;
    } sts_t;

endpackage

// File: hdl/ttpl_dp.sv
// Datapath of the triangle table point locator: request register, triangle memory,
// entry count, the scan pipeline with the containment test, and the result register.
// Depends on ttpl_pkg; driven by ttpl_ctrl through ctl_t and reports through sts_t.
module ttpl_dp
    import ttpl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  ctl_t ctl,
    output sts_t sts,
    output res_t res
);

    cmd_t             req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] sh_reg;
    tri_t             mem [TABLE_DEPTH];
    tri_t             rd_data_reg;
    tri_t             req_tri;
    tri_t             wr_data;
    tri_t             tri2_reg;
    tri_t             tri3_reg;
    tri_t             tri4_reg;
    tri_t             found_tri_reg;
    res_t             res_reg;

    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic             s3_valid_reg;
    logic             s4_valid_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [IDX_W-1:0] idx3_reg;
    logic [IDX_W-1:0] idx4_reg;
    logic             match2_reg;
    logic             match3_reg;
    logic             match4_reg;

    logic signed [DIFF_W-1:0]  abx_reg;
    logic signed [DIFF_W-1:0]  aby_reg;
    logic signed [DIFF_W-1:0]  acx_reg;
    logic signed [DIFF_W-1:0]  acy_reg;
    logic signed [DIFF_W-1:0]  apx_reg;
    logic signed [DIFF_W-1:0]  apy_reg;
    logic signed [PROD_W-1:0]  p0_reg;
    logic signed [PROD_W-1:0]  p1_reg;
    logic signed [PROD_W-1:0]  p2_reg;
    logic signed [PROD_W-1:0]  p3_reg;
    logic signed [PROD_W-1:0]  p4_reg;
    logic signed [PROD_W-1:0]  p5_reg;
    logic signed [CROSS_W-1:0] d_reg;
    logic signed [CROSS_W-1:0] nb_reg;
    logic signed [CROSS_W-1:0] ng_reg;

    logic signed [DIFF_W-1:0]  abx_next;
    logic signed [DIFF_W-1:0]  aby_next;
    logic signed [DIFF_W-1:0]  acx_next;
    logic signed [DIFF_W-1:0]  acy_next;
    logic signed [DIFF_W-1:0]  apx_next;
    logic signed [DIFF_W-1:0]  apy_next;
    logic signed [SUM_W-1:0]   sum_bg;
    logic signed [SUM_W-1:0]   d_ext;
    logic                      contained;
    logic                      issue;
    logic                      rd_en;
    logic                      wr_en;
    logic [CNT_W-1:0]          left_dec;
    logic [CNT_W-1:0]          sh_inc;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;

    assign req_tri = '{a_x: req_reg.corner_a_x, a_y: req_reg.corner_a_y,
                       b_x: req_reg.corner_b_x, b_y: req_reg.corner_b_y,
                       c_x: req_reg.corner_c_x, c_y: req_reg.corner_c_y};

    assign left_dec = left_reg - CNT_W'(1);
    assign sh_inc   = sh_reg + CNT_W'(1);
    assign issue    = ctl.scan_run && (left_reg != '0);
    assign rd_en    = issue || ctl.shift_rd;
    assign rd_addr  = ctl.shift_rd ? sh_inc[IDX_W-1:0] : left_dec[IDX_W-1:0];
    assign wr_en    = ctl.ins_write || ctl.shift_wr;
    assign wr_addr  = ctl.shift_wr ? sh_reg[IDX_W-1:0] : count_reg[IDX_W-1:0];
    assign wr_data  = ctl.shift_wr ? rd_data_reg : req_tri;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign abx_next = $signed({rd_data_reg.b_x[COORD_W-1], rd_data_reg.b_x})
                    - $signed({rd_data_reg.a_x[COORD_W-1], rd_data_reg.a_x});
    assign aby_next = $signed({rd_data_reg.b_y[COORD_W-1], rd_data_reg.b_y})
                    - $signed({rd_data_reg.a_y[COORD_W-1], rd_data_reg.a_y});
    assign acx_next = $signed({rd_data_reg.c_x[COORD_W-1], rd_data_reg.c_x})
                    - $signed({rd_data_reg.a_x[COORD_W-1], rd_data_reg.a_x});
    assign acy_next = $signed({rd_data_reg.c_y[COORD_W-1], rd_data_reg.c_y})
                    - $signed({rd_data_reg.a_y[COORD_W-1], rd_data_reg.a_y});
    assign apx_next = $signed({req_reg.point_x[COORD_W-1], req_reg.point_x})
                    - $signed({rd_data_reg.a_x[COORD_W-1], rd_data_reg.a_x});
    assign apy_next = $signed({req_reg.point_y[COORD_W-1], req_reg.point_y})
                    - $signed({rd_data_reg.a_y[COORD_W-1], rd_data_reg.a_y});

    assign sum_bg = $signed({nb_reg[CROSS_W-1], nb_reg}) + $signed({ng_reg[CROSS_W-1], ng_reg});
    assign d_ext  = $signed({d_reg[CROSS_W-1], d_reg});

    // A degenerate triangle has a zero determinant and never contains the point.
    always_comb
    begin
        if (d_reg > 0)
        begin
            contained = (nb_reg >= 0) && (ng_reg >= 0) && (sum_bg <= d_ext);
        end
        else if (d_reg < 0)
        begin
            contained = (nb_reg <= 0) && (ng_reg <= 0) && (sum_bg >= d_ext);
        end
        else
        begin
            contained = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            req_reg <= cmd;
        end
        idx1_reg   <= left_dec[IDX_W-1:0];
        idx2_reg   <= idx1_reg;
        idx3_reg   <= idx2_reg;
        idx4_reg   <= idx3_reg;
        tri2_reg   <= rd_data_reg;
        tri3_reg   <= tri2_reg;
        tri4_reg   <= tri3_reg;
        match2_reg <= (rd_data_reg == req_tri);
        match3_reg <= match2_reg;
        match4_reg <= match3_reg;
        abx_reg    <= abx_next;
        aby_reg    <= aby_next;
        acx_reg    <= acx_next;
        acy_reg    <= acy_next;
        apx_reg    <= apx_next;
        apy_reg    <= apy_next;
        p0_reg     <= abx_reg * acy_reg;
        p1_reg     <= acx_reg * aby_reg;
        p2_reg     <= apx_reg * acy_reg;
        p3_reg     <= acx_reg * apy_reg;
        p4_reg     <= abx_reg * apy_reg;
        p5_reg     <= apx_reg * aby_reg;
        d_reg      <= $signed({p0_reg[PROD_W-1], p0_reg}) - $signed({p1_reg[PROD_W-1], p1_reg});
        nb_reg     <= $signed({p2_reg[PROD_W-1], p2_reg}) - $signed({p3_reg[PROD_W-1], p3_reg});
        ng_reg     <= $signed({p4_reg[PROD_W-1], p4_reg}) - $signed({p5_reg[PROD_W-1], p5_reg});
        if (ctl.capture)
        begin
            found_tri_reg <= tri4_reg;
        end
        if (ctl.res_load)
        begin
            res_reg.status      <= ctl.res_status;
            res_reg.hit_a_x     <= ctl.res_hit ? found_tri_reg.a_x : '0;
            res_reg.hit_a_y     <= ctl.res_hit ? found_tri_reg.a_y : '0;
            res_reg.hit_b_x     <= ctl.res_hit ? found_tri_reg.b_x : '0;
            res_reg.hit_b_y     <= ctl.res_hit ? found_tri_reg.b_y : '0;
            res_reg.hit_c_x     <= ctl.res_hit ? found_tri_reg.c_x : '0;
            res_reg.hit_c_y     <= ctl.res_hit ? found_tri_reg.c_y : '0;
            res_reg.entry_count <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            left_reg     <= '0;
            sh_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (ctl.count_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end

            if (ctl.scan_start)
            begin
                left_reg <= count_reg;
            end
            else if (issue)
            begin
                left_reg <= left_dec;
            end

            if (ctl.capture)
            begin
                sh_reg <= CNT_W'(idx4_reg);
            end
            else if (ctl.shift_wr)
            begin
                sh_reg <= sh_inc;
            end

            if (ctl.scan_start)
            begin
                s1_valid_reg <= 1'b0;
                s2_valid_reg <= 1'b0;
                s3_valid_reg <= 1'b0;
                s4_valid_reg <= 1'b0;
            end
            else
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign sts.full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign sts.left_zero  = (left_reg == '0);
    assign sts.pipe_empty = !(s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg);
    assign sts.hit        = s4_valid_reg
                          && ((req_reg.opcode == OP_QUERY) ? contained : match4_reg);
    assign sts.shift_more = (sh_inc < count_reg);
    assign res            = res_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");
    assert property (@(posedge clk) disable iff (!rst_n) ctl.capture |-> s4_valid_reg)
        else $error("capture without a valid scan token");
    assert property (@(posedge clk) disable iff (!rst_n) ctl.count_inc |=> count_reg != '0)
        else $error("insert left the table empty");
`endif

endmodule

// File: hdl/ttpl_ctrl.sv
// Controller of the triangle table point locator: accepts requests, sequences insert,
// scan and shift, and owns the result valid flag.
// Depends on ttpl_pkg; drives ttpl_dp through ctl_t and reads sts_t.
module ttpl_ctrl
    import ttpl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic [1:0] cmd_opcode,
    output logic       cmd_stall,
    output logic       res_valid,
    input  logic       res_stall,
    input  sts_t       sts,
    output ctl_t       ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    state_t  state_reg;
    opcode_t op_reg;
    status_t status_reg;
    logic    res_valid_reg;
    logic    accept;
    logic    res_free;

    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign res_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        ctl            = '0;
        ctl.res_status = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                ctl.load_req   = accept;
                ctl.scan_start = accept;
            end
            S_INSERT:
            begin
                ctl.ins_write = !sts.full;
                ctl.count_inc = !sts.full;
            end
            S_SCAN:
            begin
                ctl.scan_run = !sts.hit;
                ctl.capture  = sts.hit;
            end
            S_SHIFT_RD:
            begin
                ctl.shift_rd  = sts.shift_more;
                ctl.count_dec = !sts.shift_more;
            end
            S_SHIFT_WR:
            begin
                ctl.shift_wr = 1'b1;
            end
            S_FINISH:
            begin
                ctl.res_load = res_free;
                ctl.res_hit  = (op_reg == OP_QUERY) && (status_reg == ST_DONE);
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_INSERT;
            status_reg    <= ST_DONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= opcode_t'(cmd_opcode);
                        case (opcode_t'(cmd_opcode))
                            OP_INSERT:
                            begin
                                state_reg <= S_INSERT;
                            end
                            OP_DELETE, OP_QUERY:
                            begin
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                                status_reg <= ST_DONE;
                                state_reg  <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_INSERT:
                begin
                    status_reg <= sts.full ? ST_FULL : ST_DONE;
                    state_reg  <= S_FINISH;
                end
                S_SCAN:
                begin
                    if (sts.hit)
                    begin
                        status_reg <= ST_DONE;
                        state_reg  <= (op_reg == OP_QUERY) ? S_FINISH : S_SHIFT_RD;
                    end
                    else if (sts.left_zero && sts.pipe_empty)
                    begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_FINISH;
                    end
                end
                S_SHIFT_RD:
                begin
                    state_reg <= sts.shift_more ? S_SHIFT_WR : S_FINISH;
                end
                S_SHIFT_WR:
                begin
                    state_reg <= S_SHIFT_RD;
                end
                S_FINISH:
                begin
                    if (res_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && sts.hit) |=> (state_reg == S_FINISH || state_reg == S_SHIFT_RD))
        else $error("scan did not stop at the first hit");
    assert property (@(posedge clk) disable iff (!rst_n) ctl.res_load |=> res_valid_reg)
        else $error("result loaded without valid");
    assert property (@(posedge clk) disable iff (!rst_n) (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("second request taken while busy");
`endif

endmodule

// File: hdl/triangle_table_point_locate.sv
// Triangle table point locator top level: request and result channels with valid and stall.
// The table holds up to TABLE_DEPTH triangles; requests insert, delete or locate a point.
// A request is taken when cmd_valid is high and cmd_stall is low; one result follows
// each request on res, taken when res_valid is high and res_stall is low.
// One request is worked at a time; cmd_stall stays high until its result is loaded.
// Insert passes through the insert state to the finish state; the reserved opcode goes
// straight to the finish state. Query and delete read the table newest to oldest, one
// entry per cycle through the single memory read port into a four-stage cross-product
// pipeline. A hit stops the walk; a walk that finds nothing ends once every entry has
// been read and the pipeline has drained, and on an empty table it ends without a read.
// A delete that hits then moves each newer entry down one place, with a read state and
// a write state per entry, and then lowers the entry count.
// The result sits in an output register; the next request may be taken while it
// waits, and a stalled result holds until res_stall falls.
// Reset empties the table and clears all valid flags; there is no clearing pass.
// Depends on ttpl_pkg, ttpl_ctrl and ttpl_dp.
module triangle_table_point_locate
    import ttpl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    ctl_t ctl;
    sts_t sts;

    ttpl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_opcode (cmd.opcode),
        .cmd_stall  (cmd_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .sts        (sts),
        .ctl        (ctl)
    );

    ttpl_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .sts   (sts),
        .res   (res)
    );

endmodule
